// File: rtl/core/piecewise_gain_scheduler_macros.svh
// Assertion macros shared by the gain scheduler RTL.
`ifndef PIECEWISE_GAIN_SCHEDULER_MACROS_SVH
`define PIECEWISE_GAIN_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PGS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gain scheduler assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define PGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gain scheduler assertion failed");

`endif

// File: rtl/core/pgs_pkg.sv
// Package with widths, types, register codes and reset values of the gain scheduler.
package pgs_pkg;

    // Field widths.
    localparam int MAG_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int SET_W     = 48;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int PROD_W    = 32;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_IDX_W = 3;

    // Default number of quotient bits resolved in each divider stage.
    localparam int DIV_STEPS = 2;

    // Fraction value that stands for one in Q1.16.
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // Gain set: index 2 is kp, 1 is ki, 0 is kd, matching the register packing.
    typedef logic [2:0][GAIN_W-1:0] pgs_gains_t;

    typedef enum logic [1:0] {
        ZONE_ZERO       = 2'd0,
        ZONE_LOW_BLEND  = 2'd1,
        ZONE_HIGH_BLEND = 2'd2,
        ZONE_FAR        = 2'd3
    } pgs_zone_t;

    // Data that rides along with a division.
    typedef struct packed {
        pgs_zone_t  zone;
        pgs_gains_t lo_set;
        pgs_gains_t hi_set;
    } pgs_side_t;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LIN_FAR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIN_MID   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIN_CLOSE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIN_LIM   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ANG_FAR   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ANG_MID   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ANG_CLOSE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ANG_LIM   = 3'd7;

    // Reset values: gains kp/ki/kd in Q8.8, limits far/medium in Q16.8.
    localparam logic [SET_W-1:0] RST_LIN_FAR   = 48'h0A00_0000_0300;
    localparam logic [SET_W-1:0] RST_LIN_MID   = 48'h0600_0080_0200;
    localparam logic [SET_W-1:0] RST_LIN_CLOSE = 48'h0200_001A_0100;
    localparam logic [SET_W-1:0] RST_LIN_LIM   = 48'h002400_001800;
    localparam logic [SET_W-1:0] RST_ANG_FAR   = 48'h0600_0000_0180;
    localparam logic [SET_W-1:0] RST_ANG_MID   = 48'h0400_0033_0100;
    localparam logic [SET_W-1:0] RST_ANG_CLOSE = 48'h0200_001A_0080;
    localparam logic [SET_W-1:0] RST_ANG_LIM   = 48'h005A00_002D00;

endpackage

// File: rtl/core/pgs_cmd_if.sv
// Request channel interface: table select and error magnitude.
interface pgs_cmd_if import pgs_pkg::*;;

    logic             valid;
    logic             ready;
    logic             action;
    logic [MAG_W-1:0] magnitude;

    modport source (output valid, output action, output magnitude, input ready);
    modport sink   (input valid, input action, input magnitude, output ready);

endinterface

// File: rtl/core/pgs_rsp_if.sv
// Response channel interface: scheduled gains and zone.
interface pgs_rsp_if import pgs_pkg::*;;

    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [1:0]        zone;

    modport source (output valid, output gain_p, output gain_i, output gain_d,
                    output zone, input ready);
    modport sink   (input valid, input gain_p, input gain_i, input gain_d,
                    input zone, output ready);

endinterface

// File: rtl/core/piecewise_gain_scheduler.sv
// Top level of the piecewise-linear PID gain scheduler.
//
// A transaction on cmd carries a table select (action: 0 linear, 1 angular)
// and an unsigned Q16.8 error magnitude. Each one yields exactly one
// transaction on rsp with the Q8.8 gains kp, ki, kd and the zone code.
// Gain sets and thresholds sit in eight 48-bit APB registers at byte
// address 8*i; they are meant to change only while no work is in flight.
// The pipeline accepts one transaction per cycle while rsp is not stalled.
// A request passes the zone register, the divider operand register,
// the divider stages, the multiply register and the output register;
// each divider stage resolves DIV_STEPS_PER_STAGE fraction bits (a divisor of 16).
// When rsp is stalled the whole pipeline holds and cmd.ready drops, so no
// transaction is lost or repeated. Reset empties the pipeline and loads
// the default gain tables and thresholds.
`include "piecewise_gain_scheduler_macros.svh"

module piecewise_gain_scheduler import pgs_pkg::*; #(
    parameter int DIV_STEPS_PER_STAGE = DIV_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    pgs_cmd_if.sink           cmd,
    pgs_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers.
    logic [SET_W-1:0] lin_far_reg, lin_mid_reg, lin_close_reg, lin_lim_reg;
    logic [SET_W-1:0] ang_far_reg, ang_mid_reg, ang_close_reg, ang_lim_reg;
    logic             cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [SET_W-1:0] cfg_rd;

    // Pipeline control.
    logic en;

    // Stage 1: zone decision.
    pgs_gains_t       far_set, mid_set, close_set;
    logic [SET_W-1:0] lim_sel;
    logic [MAG_W-1:0] far_t, mid_t;
    pgs_side_t        s1_side_next;
    logic             s1_valid_reg;
    pgs_side_t        s1_side_reg;
    logic [MAG_W-1:0] s1_mag_reg, s1_far_reg, s1_mid_reg;

    // Stage 2: divider operands.
    logic [MAG_W-1:0] s2_num_next, s2_div_next;
    logic             s2_q16_next;
    logic             s2_valid_reg;
    logic [MAG_W-1:0] s2_rem_reg, s2_div_reg;
    logic             s2_q16_reg;
    pgs_side_t        s2_side_reg;

    // Divider output.
    logic              div_valid;
    logic [FRAC_W-1:0] div_frac;
    pgs_side_t         div_side;

    // Multiply stage.
    logic [FRAC_W-1:0] frac_inv;
    logic [PROD_W-1:0] lo_prod_next [3];
    logic [PROD_W-1:0] hi_prod_next [3];
    logic              m1_valid_reg;
    pgs_zone_t         m1_zone_reg;
    logic [PROD_W-1:0] m1_lo_prod_reg [3];
    logic [PROD_W-1:0] m1_hi_prod_reg [3];

    // Output stage.
    pgs_gains_t out_gain_next;
    logic       out_valid_reg;
    pgs_gains_t out_gain_reg;
    pgs_zone_t  out_zone_reg;

    // APB access: the register index sits above the byte offset.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_far_reg   <= RST_LIN_FAR;
            lin_mid_reg   <= RST_LIN_MID;
            lin_close_reg <= RST_LIN_CLOSE;
            lin_lim_reg   <= RST_LIN_LIM;
            ang_far_reg   <= RST_ANG_FAR;
            ang_mid_reg   <= RST_ANG_MID;
            ang_close_reg <= RST_ANG_CLOSE;
            ang_lim_reg   <= RST_ANG_LIM;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LIN_FAR:   lin_far_reg   <= pwdata[SET_W-1:0];
                REG_LIN_MID:   lin_mid_reg   <= pwdata[SET_W-1:0];
                REG_LIN_CLOSE: lin_close_reg <= pwdata[SET_W-1:0];
                REG_LIN_LIM:   lin_lim_reg   <= pwdata[SET_W-1:0];
                REG_ANG_FAR:   ang_far_reg   <= pwdata[SET_W-1:0];
                REG_ANG_MID:   ang_mid_reg   <= pwdata[SET_W-1:0];
                REG_ANG_CLOSE: ang_close_reg <= pwdata[SET_W-1:0];
                REG_ANG_LIM:   ang_lim_reg   <= pwdata[SET_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (cfg_idx)
            REG_LIN_FAR:   cfg_rd = lin_far_reg;
            REG_LIN_MID:   cfg_rd = lin_mid_reg;
            REG_LIN_CLOSE: cfg_rd = lin_close_reg;
            REG_LIN_LIM:   cfg_rd = lin_lim_reg;
            REG_ANG_FAR:   cfg_rd = ang_far_reg;
            REG_ANG_MID:   cfg_rd = ang_mid_reg;
            REG_ANG_CLOSE: cfg_rd = ang_close_reg;
            REG_ANG_LIM:   cfg_rd = ang_lim_reg;
            default:       cfg_rd = '0;
        endcase
    end
    assign prdata = {{(DATA_W-SET_W){1'b0}}, cfg_rd};

    // The pipeline moves whenever the output register is free or being drained.
    assign en        = !out_valid_reg || rsp.ready;
    assign cmd.ready = en;

    // Stage 1: pick the table and find the zone and the two gain sets.
    assign far_set   = cmd.action ? ang_far_reg   : lin_far_reg;
    assign mid_set   = cmd.action ? ang_mid_reg   : lin_mid_reg;
    assign close_set = cmd.action ? ang_close_reg : lin_close_reg;
    assign lim_sel   = cmd.action ? ang_lim_reg   : lin_lim_reg;
    assign far_t     = lim_sel[SET_W-1:MAG_W];
    assign mid_t     = lim_sel[MAG_W-1:0];

    always_comb
    begin
        if (cmd.magnitude > far_t)
        begin
            s1_side_next.zone   = ZONE_FAR;
            s1_side_next.lo_set = far_set;
            s1_side_next.hi_set = far_set;
        end
        else if (cmd.magnitude > mid_t)
        begin
            s1_side_next.zone   = ZONE_HIGH_BLEND;
            s1_side_next.lo_set = mid_set;
            s1_side_next.hi_set = far_set;
        end
        else if (cmd.magnitude != '0)
        begin
            s1_side_next.zone   = ZONE_LOW_BLEND;
            s1_side_next.lo_set = close_set;
            s1_side_next.hi_set = mid_set;
        end
        else
        begin
            s1_side_next.zone   = ZONE_ZERO;
            s1_side_next.lo_set = close_set;
            s1_side_next.hi_set = close_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_mag_reg  <= cmd.magnitude;
            s1_far_reg  <= far_t;
            s1_mid_reg  <= mid_t;
        end
    end

    // Stage 2: offset into the zone and its span. Fixed zones divide
    // zero by one, and their equal gain sets make the fraction moot.
    always_comb
    begin
        case (s1_side_reg.zone)
            ZONE_HIGH_BLEND:
            begin
                s2_num_next = s1_mag_reg - s1_mid_reg;
                s2_div_next = s1_far_reg - s1_mid_reg;
            end
            ZONE_LOW_BLEND:
            begin
                s2_num_next = s1_mag_reg;
                s2_div_next = s1_mid_reg;
            end
            default:
            begin
                s2_num_next = '0;
                s2_div_next = MAG_W'(1);
            end
        endcase
        // An offset equal to the span is a fraction of exactly one.
        s2_q16_next = (s2_num_next == s2_div_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_rem_reg  <= s2_q16_next ? '0 : s2_num_next;
            s2_div_reg  <= s2_div_next;
            s2_q16_reg  <= s2_q16_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    // Fraction divider.
    pgs_divider #(
        .STEPS (DIV_STEPS_PER_STAGE)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_rem    (s2_rem_reg),
        .in_div    (s2_div_reg),
        .in_q16    (s2_q16_reg),
        .in_side   (s2_side_reg),
        .out_valid (div_valid),
        .out_frac  (div_frac),
        .out_side  (div_side)
    );

    // Multiply stage: weight the lower set by one minus the fraction and
    // the upper set by the fraction.
    assign frac_inv = FRAC_ONE - div_frac;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_prod_next[k] = PROD_W'(div_side.lo_set[k]) * PROD_W'(frac_inv);
            hi_prod_next[k] = PROD_W'(div_side.hi_set[k]) * PROD_W'(div_frac);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (en)
            m1_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_zone_reg <= div_side.zone;
            for (int k = 0; k < 3; k++)
            begin
                m1_lo_prod_reg[k] <= lo_prod_next[k];
                m1_hi_prod_reg[k] <= hi_prod_next[k];
            end
        end
    end

    // Output stage: sum the weighted gains and drop the fraction bits.
    always_comb
    begin
        logic [PROD_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum              = m1_lo_prod_reg[k] + m1_hi_prod_reg[k];
            out_gain_next[k] = sum[PROD_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_gain_reg <= out_gain_next;
            out_zone_reg <= m1_zone_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.gain_p = out_gain_reg[2];
    assign rsp.gain_i = out_gain_reg[1];
    assign rsp.gain_d = out_gain_reg[0];
    assign rsp.zone   = out_zone_reg;

    // A fraction of one has no bits below the integer bit.
    `PGS_ASSERT_IMPL(a_frac_range, div_valid && div_frac[FRAC_BITS],
                     div_frac[FRAC_BITS-1:0] == '0)
    // A blend below the full span starts with a remainder under the divisor.
    `PGS_ASSERT_IMPL(a_rem_below_div, s2_valid_reg && !s2_q16_reg, s2_rem_reg < s2_div_reg)
    // Fixed zones carry the same set on both sides of the blend.
    `PGS_ASSERT_IMPL(a_fixed_zone_sets,
                     s2_valid_reg &&
                     (s2_side_reg.zone == ZONE_ZERO || s2_side_reg.zone == ZONE_FAR),
                     s2_side_reg.lo_set == s2_side_reg.hi_set)
    // A stalled result freezes the pipeline, so no new request is taken.
    `PGS_ASSERT_IMPL(a_stall_holds_input, rsp.valid && !rsp.ready, !cmd.ready)
    // A stalled result stays on the channel in the next cycle.
    `PGS_ASSERT_NEXT(a_stall_holds_result, rsp.valid && !rsp.ready, rsp.valid)

endmodule

// File: rtl/core/pgs_divider.sv
// Pipelined restoring divider that produces the Q1.16 blend fraction.
module pgs_divider import pgs_pkg::*; #(
    parameter int STEPS = DIV_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [MAG_W-1:0]  in_rem,
    input  logic [MAG_W-1:0]  in_div,
    input  logic              in_q16,
    input  pgs_side_t         in_side,
    output logic              out_valid,
    output logic [FRAC_W-1:0] out_frac,
    output pgs_side_t         out_side
);

    localparam int NSTG = FRAC_BITS / STEPS;

    // Stage inputs.
    logic              src_valid [NSTG];
    logic [MAG_W-1:0]  src_rem   [NSTG];
    logic [MAG_W-1:0]  src_div   [NSTG];
    logic [FRAC_W-1:0] src_q     [NSTG];
    pgs_side_t         src_side  [NSTG];

    // Stage registers and their next values.
    logic              valid_reg [NSTG];
    logic [MAG_W-1:0]  rem_reg   [NSTG];
    logic [MAG_W-1:0]  rem_next  [NSTG];
    logic [MAG_W-1:0]  div_reg   [NSTG];
    logic [FRAC_W-1:0] q_reg     [NSTG];
    logic [FRAC_W-1:0] q_next    [NSTG];
    pgs_side_t         side_reg  [NSTG];

    genvar g;
    generate
        for (g = 0; g < NSTG; g++)
        begin : g_stage
            // The first stage takes the operands, later stages the stage before.
            if (g == 0)
            begin : g_first
                assign src_valid[g] = in_valid;
                assign src_rem[g]   = in_rem;
                assign src_div[g]   = in_div;
                assign src_q[g]     = {{FRAC_BITS{1'b0}}, in_q16};
                assign src_side[g]  = in_side;
            end
            else
            begin : g_rest
                assign src_valid[g] = valid_reg[g-1];
                assign src_rem[g]   = rem_reg[g-1];
                assign src_div[g]   = div_reg[g-1];
                assign src_q[g]     = q_reg[g-1];
                assign src_side[g]  = side_reg[g-1];
            end

            // Shift, compare and subtract once per quotient bit.
            always_comb
            begin
                logic [MAG_W-1:0]  r;
                logic [FRAC_W-1:0] q;
                logic [MAG_W:0]    t;
                r = src_rem[g];
                q = src_q[g];
                t = '0;
                for (int k = 0; k < STEPS; k++)
                begin
                    t = {r, 1'b0};
                    if (t >= {1'b0, src_div[g]})
                    begin
                        r = MAG_W'(t - {1'b0, src_div[g]});
                        q = {q[FRAC_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = t[MAG_W-1:0];
                        q = {q[FRAC_W-2:0], 1'b0};
                    end
                end
                rem_next[g] = r;
                q_next[g]   = q;
            end

            // Valid bit of the stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (en)
                    valid_reg[g] <= src_valid[g];
            end

            // Payload of the stage.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= rem_next[g];
                    div_reg[g]  <= src_div[g];
                    q_reg[g]    <= q_next[g];
                    side_reg[g] <= src_side[g];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NSTG-1];
    assign out_frac  = q_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

// File: tb/piecewise_gain_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the piecewise-linear PID gain scheduler.
module piecewise_gain_scheduler_tb;
    import pgs_pkg::*;

    localparam int MAX_WAIT       = 11;
    localparam int LATENCY_TAIL   = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 200;

    // One scheduled result: gains in Q8.8 and the zone that produced them.
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        pgs_zone_t         zone;
    } scheduled_gains_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pgs_cmd_if cmd_ch();
    pgs_rsp_if rsp_ch();

    // Shadow copy of the gain tables and thresholds, indexed by register code.
    logic [SET_W-1:0]  sched_regs [8];
    scheduled_gains_t  pending_gains [$];
    logic              failed = 1'b0;
    logic              steady_source = 1'b0;
    logic              steady_sink = 1'b0;

    piecewise_gain_scheduler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch.sink),
        .rsp     (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Weighted blend of two Q8.8 gains with a Q1.16 fraction, truncated.
    function automatic logic [GAIN_W-1:0] blend_gain(logic [GAIN_W-1:0] lo_g,
                                                     logic [GAIN_W-1:0] hi_g,
                                                     logic [63:0] frac);
        logic [63:0] acc;
        acc = 64'(lo_g) * (64'(FRAC_ONE) - frac) + 64'(hi_g) * frac;
        return acc[FRAC_BITS +: GAIN_W];
    endfunction

    // Zone selection and interpolation for one request.
    function automatic scheduled_gains_t schedule_gains(logic action,
                                                        logic [MAG_W-1:0] mag);
        logic [SET_W-1:0] far_set;
        logic [SET_W-1:0] mid_set;
        logic [SET_W-1:0] close_set;
        logic [SET_W-1:0] lims;
        logic [SET_W-1:0] lo_set;
        logic [SET_W-1:0] hi_set;
        logic [63:0]      m;
        logic [63:0]      far_t;
        logic [63:0]      mid_t;
        logic [63:0]      frac;
        scheduled_gains_t res;
        far_set   = sched_regs[action ? REG_ANG_FAR : REG_LIN_FAR];
        mid_set   = sched_regs[action ? REG_ANG_MID : REG_LIN_MID];
        close_set = sched_regs[action ? REG_ANG_CLOSE : REG_LIN_CLOSE];
        lims      = sched_regs[action ? REG_ANG_LIM : REG_LIN_LIM];
        m         = 64'(mag);
        far_t     = 64'(lims[2*MAG_W-1:MAG_W]);
        mid_t     = 64'(lims[MAG_W-1:0]);
        if (m > far_t)
        begin
            lo_set   = far_set;
            hi_set   = far_set;
            frac     = '0;
            res.zone = ZONE_FAR;
        end
        else if (m > mid_t)
        begin
            lo_set   = mid_set;
            hi_set   = far_set;
            frac     = ((m - mid_t) << FRAC_BITS) / (far_t - mid_t);
            res.zone = ZONE_HIGH_BLEND;
        end
        else if (m > 0)
        begin
            lo_set   = close_set;
            hi_set   = mid_set;
            frac     = (m << FRAC_BITS) / mid_t;
            res.zone = ZONE_LOW_BLEND;
        end
        else
        begin
            lo_set   = close_set;
            hi_set   = close_set;
            frac     = '0;
            res.zone = ZONE_ZERO;
        end
        res.kp = blend_gain(lo_set[47:32], hi_set[47:32], frac);
        res.ki = blend_gain(lo_set[31:16], hi_set[31:16], frac);
        res.kd = blend_gain(lo_set[15:0], hi_set[15:0], frac);
        return res;
    endfunction

    function automatic void compare_field(string field, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            failed = 1'b1;
        end
    endfunction

    function automatic logic [SET_W-1:0] random_set();
        return SET_W'({$urandom(), $urandom()});
    endfunction

    // Gain set with the extremes drawn now and then.
    function automatic logic [SET_W-1:0] random_gains();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return random_set();
        endcase
    endfunction

    // Threshold pair: ordered, zero medium, misordered, far at full scale or fully random.
    function automatic logic [SET_W-1:0] random_limits();
        logic [MAG_W-1:0] far_t;
        logic [MAG_W-1:0] mid_t;
        case ($urandom_range(0, 6))
            0, 1, 2:
            begin
                mid_t = MAG_W'($urandom_range(0, 'h8000));
                far_t = mid_t + MAG_W'($urandom_range(1, 'h8000));
            end
            3:
            begin
                mid_t = '0;
                far_t = MAG_W'($urandom_range(0, 'h4000));
            end
            4:
            begin
                far_t = MAG_W'($urandom_range(0, 'h4000));
                mid_t = far_t + MAG_W'($urandom_range(0, 'h4000));
            end
            5:
            begin
                far_t = '1;
                mid_t = MAG_W'($urandom_range(0, 'h100000));
            end
            default:
            begin
                far_t = MAG_W'($urandom());
                mid_t = MAG_W'($urandom());
            end
        endcase
        return {far_t, mid_t};
    endfunction

    // Magnitude aimed mostly at the configured zones and their boundaries.
    function automatic logic [MAG_W-1:0] pick_magnitude(logic action);
        logic [SET_W-1:0] lims;
        logic [31:0]      far_t;
        logic [31:0]      mid_t;
        logic [31:0]      top;
        logic [31:0]      span;
        lims  = sched_regs[action ? REG_ANG_LIM : REG_LIN_LIM];
        far_t = 32'(lims[2*MAG_W-1:MAG_W]);
        mid_t = 32'(lims[MAG_W-1:0]);
        top   = (far_t > mid_t) ? far_t : mid_t;
        span  = top + top / 4 + 2;
        if (span > 32'hFF_FFFF)
            span = 32'hFF_FFFF;
        case ($urandom_range(0, 9))
            0, 1:       return MAG_W'($urandom());
            7:          return MAG_W'(far_t + $urandom_range(0, 4) - 2);
            8:          return MAG_W'(mid_t + $urandom_range(0, 4) - 2);
            9:          return MAG_W'($urandom_range(0, 1));
            default:    return MAG_W'($urandom_range(0, span));
        endcase
    endfunction

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SET_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sched_regs[idx] = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read with a check against the shadow copy.
    task automatic read_reg(input logic [REG_IDX_W-1:0] idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 3'b000});
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        compare_field("register readback", DATA_W'(sched_regs[idx]),
                      DATA_W'(prdata[SET_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one request after a random gap and record its expected gains on acceptance.
    task automatic send_request(input logic action, input logic [MAG_W-1:0] mag);
        int gap;
        gap = steady_source ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.action    <= action;
        cmd_ch.magnitude <= mag;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        pending_gains.push_back(schedule_gains(action, mag));
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_gains.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Default tables: each boundary of the linear table and both angular thresholds.
    task automatic test_reset_tables();
        logic [MAG_W-1:0] lin_mags [9];
        logic [MAG_W-1:0] ang_mags [4];
        lin_mags = '{24'h000000, 24'h000001, 24'h0017FF, 24'h001800, 24'h001801,
                     24'h0023FF, 24'h002400, 24'h002401, 24'hFFFFFF};
        ang_mags = '{24'h002D00, 24'h002D01, 24'h005A00, 24'h005A01};
        foreach (lin_mags[k])
            send_request(1'b0, lin_mags[k]);
        foreach (ang_mags[k])
            send_request(1'b1, ang_mags[k]);
        wait_drained();
    endtask

    // All registers at zero, at all ones and at random values, each read back.
    task automatic test_register_access();
        logic [SET_W-1:0] val;
        for (int pass = 0; pass < 3; pass++)
        begin
            for (int r = 0; r < $size(sched_regs); r++)
            begin
                val = (pass == 0) ? '0 : (pass == 1) ? '1 : random_set();
                write_reg(REG_IDX_W'(r), val);
            end
            for (int r = 0; r < $size(sched_regs); r++)
                read_reg(REG_IDX_W'(r));
            if (pass < 2)
            begin
                send_request(1'b0, MAG_W'($urandom()));
                send_request(1'b1, MAG_W'($urandom()));
                wait_drained();
            end
        end
    endtask

    // Misordered thresholds, zero medium threshold, equal thresholds, magnitudes on a threshold.
    task automatic test_special_cases();
        write_reg(REG_LIN_FAR, '1);
        write_reg(REG_LIN_MID, '0);
        write_reg(REG_LIN_CLOSE, 48'hFFFF_0000_8001);
        write_reg(REG_LIN_LIM, {24'h000100, 24'h000800});
        send_request(1'b0, 24'h000080);
        send_request(1'b0, 24'h000100);
        send_request(1'b0, 24'h000900);
        wait_drained();

        write_reg(REG_ANG_FAR, random_set());
        write_reg(REG_ANG_MID, random_set());
        write_reg(REG_ANG_CLOSE, random_set());
        write_reg(REG_ANG_LIM, {24'h000010, 24'h000000});
        send_request(1'b1, 24'h000000);
        send_request(1'b1, 24'h000001);
        send_request(1'b1, 24'h000010);
        send_request(1'b1, 24'hFFFFFF);
        wait_drained();

        // Both thresholds at full scale: the top magnitude lands exactly on the medium gains.
        write_reg(REG_LIN_LIM, {24'hFFFFFF, 24'hFFFFFF});
        send_request(1'b0, 24'hFFFFFF);
        send_request(1'b0, 24'h7FFFFF);
        wait_drained();

        write_reg(REG_LIN_LIM, {24'h000100, 24'h000100});
        send_request(1'b0, 24'h000100);
        send_request(1'b0, 24'h000101);
        wait_drained();
    endtask

    task automatic randomize_tables();
        write_reg(REG_LIN_FAR, random_gains());
        write_reg(REG_LIN_MID, random_gains());
        write_reg(REG_LIN_CLOSE, random_gains());
        write_reg(REG_LIN_LIM, random_limits());
        write_reg(REG_ANG_FAR, random_gains());
        write_reg(REG_ANG_MID, random_gains());
        write_reg(REG_ANG_CLOSE, random_gains());
        write_reg(REG_ANG_LIM, random_limits());
    endtask

    // Random requests in phases, each with freshly drawn tables and thresholds.
    task automatic test_random_traffic();
        logic action;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            randomize_tables();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Redraw the idling mode now and then so full-rate stretches occur.
                if (n % 50 == 0)
                begin
                    steady_source = ($urandom_range(0, 3) == 0);
                    steady_sink   = ($urandom_range(0, 3) == 0);
                end
                // Halfway through one phase, let the pipeline empty completely.
                if (phase == RANDOM_PHASES / 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                action = 1'($urandom_range(0, 1));
                send_request(action, pick_magnitude(action));
            end
        end
        steady_source = 1'b0;
        steady_sink   = 1'b0;
    endtask

    // Result side: random stall before each transaction.
    initial
    begin : result_sink
        int stall;
        rsp_ch.ready = 1'b0;
        forever
        begin
            stall = steady_sink ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    // Compare each result transaction with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        scheduled_gains_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_gains.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h %h %h %h", $time,
                         rsp_ch.gain_p, rsp_ch.gain_i, rsp_ch.gain_d, rsp_ch.zone);
                failed = 1'b1;
            end
            else
            begin
                want = pending_gains.pop_front();
                compare_field("gain_p", DATA_W'(want.kp), DATA_W'(rsp_ch.gain_p));
                compare_field("gain_i", DATA_W'(want.ki), DATA_W'(rsp_ch.gain_i));
                compare_field("gain_d", DATA_W'(want.kd), DATA_W'(rsp_ch.gain_d));
                compare_field("zone", DATA_W'(want.zone), DATA_W'(rsp_ch.zone));
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1 && pready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.action    = 1'b0;
        cmd_ch.magnitude = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        sched_regs[REG_LIN_FAR]   = RST_LIN_FAR;
        sched_regs[REG_LIN_MID]   = RST_LIN_MID;
        sched_regs[REG_LIN_CLOSE] = RST_LIN_CLOSE;
        sched_regs[REG_LIN_LIM]   = RST_LIN_LIM;
        sched_regs[REG_ANG_FAR]   = RST_ANG_FAR;
        sched_regs[REG_ANG_MID]   = RST_ANG_MID;
        sched_regs[REG_ANG_CLOSE] = RST_ANG_CLOSE;
        sched_regs[REG_ANG_LIM]   = RST_ANG_LIM;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_tables();
        test_register_access();
        test_special_cases();
        test_random_traffic();

        wait_drained();
        repeat (LATENCY_TAIL) @(posedge clk);
        if (!failed && pending_gains.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pgs_pkg.sv
rtl/core/pgs_cmd_if.sv
rtl/core/pgs_rsp_if.sv
rtl/core/pgs_divider.sv
rtl/core/piecewise_gain_scheduler.sv
tb/piecewise_gain_scheduler_tb.sv
